// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FPSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FPSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/fpsa_pkg.sv -----
// Package: types, constants and grid geometry helpers for the five-point stencil core.
`timescale 1ns / 1ps
package fpsa_pkg;

  localparam int GRID_W     = 6;
  localparam int IDX_W      = 14;
  localparam int SAMPLE_W   = 32;
  localparam int VALUE_W    = 47;
  localparam int DIFF_W     = 35;
  localparam int SCALE_W    = 12;
  localparam int COL_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int MAX_GRID_DEF = 62;
  localparam int WIN_AW_DEF   = 7;

  localparam logic [GRID_W-1:0] GRID_SIZE_RST = 6'd31;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_SHAPE = 2'd1;

  typedef enum logic {
    SHAPE_SQUARE = 1'b0,
    SHAPE_L      = 1'b1
  } shape_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [GRID_W-1:0] row;
    logic [COL_W-1:0]  col;
    logic              bottom;
  } cursor_t;

  typedef struct packed {
    logic             has_l;
    logic             has_r;
    logic             has_u;
    logic             has_d;
    logic [IDX_W-1:0] up;
    logic [IDX_W-1:0] dn;
    logic [IDX_W-1:0] ln;
  } nb_t;

  typedef struct packed {
    logic             has_l;
    logic             has_r;
    logic             has_u;
    logic             has_d;
    logic [IDX_W-1:0] idx;
    logic             vend;
    logic             rlast;
  } meta_t;

  function automatic logic [GRID_W-1:0] clamp_n(logic [GRID_W-1:0] raw,
                                                logic [GRID_W-1:0] maxg);
    logic [GRID_W-1:0] n;
    n = raw;
    if (n < 6'd2) n = 6'd2;
    if (n > maxg) n = maxg;
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] grid_total(logic [GRID_W-1:0] n, shape_t shp);
    logic [IDX_W-1:0] tri_w;
    tri_w = (shp == SHAPE_L) ? (IDX_W'(n) * IDX_W'(3) + IDX_W'(2)) : IDX_W'(n);
    return tri_w * IDX_W'(n);
  endfunction

  function automatic logic [SCALE_W-1:0] grid_scale(logic [GRID_W-1:0] n);
    logic [IDX_W-1:0] np1;
    logic [IDX_W-1:0] sq;
    np1 = IDX_W'(n) + IDX_W'(1);
    sq  = np1 * np1;
    return sq[SCALE_W-1:0];
  endfunction

  function automatic nb_t nb_info(cursor_t c, logic [GRID_W-1:0] n, shape_t shp);
    nb_t              r;
    logic [COL_W-1:0] w;
    logic [COL_W-1:0] col1;
    logic [GRID_W:0]  row1;
    w     = {n, 1'b1};
    col1  = c.col + COL_W'(1);
    row1  = {1'b0, c.row} + 7'd1;
    r.has_l = (c.col != '0);
    if (shp == SHAPE_SQUARE) begin
      r.has_r = col1 < COL_W'(n);
      r.has_u = (c.row != '0);
      r.has_d = row1 < {1'b0, n};
      r.up    = c.idx - IDX_W'(n);
      r.dn    = c.idx + IDX_W'(n);
    end else if (!c.bottom) begin
      r.has_r = col1 < w;
      r.has_u = (c.row != '0);
      r.has_d = (row1 < {1'b0, n}) || (c.col < COL_W'(n));
      r.up    = c.idx - IDX_W'(w);
      r.dn    = c.idx + IDX_W'(w);
    end else begin
      r.has_r = col1 < COL_W'(n);
      r.has_u = 1'b1;
      r.has_d = c.row < n;
      r.up    = (c.row == '0) ? (c.idx - IDX_W'(w)) : (c.idx - IDX_W'(n));
      r.dn    = c.idx + IDX_W'(n);
    end
    if (r.has_d)      r.ln = r.dn;
    else if (r.has_r) r.ln = c.idx + IDX_W'(1);
    else              r.ln = c.idx;
    return r;
  endfunction

  function automatic cursor_t cur_next(cursor_t c, logic [GRID_W-1:0] n, shape_t shp);
    cursor_t          r;
    logic [COL_W-1:0] cw;
    r     = c;
    r.idx = c.idx + IDX_W'(1);
    cw    = (shp == SHAPE_SQUARE || c.bottom) ? COL_W'(n) : {n, 1'b1};
    if (c.col + COL_W'(1) == cw) begin
      r.col = '0;
      if (shp == SHAPE_L && !c.bottom && (c.row + GRID_W'(1) == n)) begin
        r.bottom = 1'b1;
        r.row    = '0;
      end else begin
        r.row = c.row + GRID_W'(1);
      end
    end else begin
      r.col = c.col + COL_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- hdl/fpsa_stream_if.sv -----
// Stream interfaces: grid samples in, stencil results out.
`timescale 1ns / 1ps
interface fpsa_in_if
  import fpsa_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fpsa_out_if
  import fpsa_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [IDX_W-1:0]          result_index;
  logic                      vector_end;
  logic                      run_last;
  modport source (output valid, output result_value, output result_index,
                  output vector_end, output run_last, input ready);
  modport sink   (input valid, input result_value, input result_index,
                  input vector_end, input run_last, output ready);
endinterface

// ----- hdl/fpsa_window.sv -----
// Sample window: two mirrored memories, one write port and four registered reads.
`timescale 1ns / 1ps
module fpsa_window
  import fpsa_pkg::*;
#(
  parameter int WIN_AW = WIN_AW_DEF
) (
  input  logic                clk,
  input  logic                we,
  input  logic [WIN_AW-1:0]   waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                re,
  input  logic [WIN_AW-1:0]   raddr_c,
  input  logic [WIN_AW-1:0]   raddr_r,
  input  logic [WIN_AW-1:0]   raddr_u,
  input  logic [WIN_AW-1:0]   raddr_d,
  output logic [SAMPLE_W-1:0] rdata_c,
  output logic [SAMPLE_W-1:0] rdata_r,
  output logic [SAMPLE_W-1:0] rdata_u,
  output logic [SAMPLE_W-1:0] rdata_d
);

  localparam int DEPTH = 1 << WIN_AW;

  logic [SAMPLE_W-1:0] mem_a [DEPTH];
  logic [SAMPLE_W-1:0] mem_b [DEPTH];

  // read-first: a read in the write cycle returns the old word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_c <= mem_a[raddr_c];
      rdata_r <= mem_a[raddr_r];
    end
    if (we) mem_a[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_u <= mem_b[raddr_u];
      rdata_d <= mem_b[raddr_d];
    end
    if (we) mem_b[waddr] <= wdata;
  end

endmodule

// ----- hdl/five_point_stencil_apply_core.sv -----
// Top level: streamed five-point Laplacian stencil over a square or L-shaped grid.
//
//   port        dir   transfer moves
//   in_stream   sink  one grid sample, index order
//   out_stream  src   one stencil result with index and end flags
//   cfg_*       in    register write, index 0 grid_size, 1 domain_shape
//
// One sample per cycle while no result is due and the output is not stalled; a sample
// that releases k results holds in_stream.ready low until its last result issues, set by
// the single window read slot per result. Results pass s1, s2 and the output register.
// Synchronous active-low reset clears counters and pipeline valids and sets config to defaults.
// Output stall freezes the read pipeline; samples are still taken while no result is due.
`timescale 1ns / 1ps
module five_point_stencil_apply_core
  import fpsa_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF,
  parameter int WIN_AW   = WIN_AW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fpsa_in_if.sink               in_stream,
  fpsa_out_if.source            out_stream,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [GRID_W-1:0] MAXG = GRID_W'(MAX_GRID);

  logic [GRID_W-1:0] grid_r, grid_nxt;
  shape_t            shape_r, shape_nxt;
  logic [IDX_W-1:0]  wr_cnt_r, wr_cnt_nxt, wr_base;
  logic              fin_r, fin_nxt;
  cursor_t           cur_r, cur_nxt, cur1;
  nb_t               nb0, nb1;

  logic [GRID_W-1:0]  n_eff;
  logic [IDX_W-1:0]   total;
  logic [SCALE_W-1:0] scale;
  logic elig0, elig1, adv, issue, end_vec, in_fire;

  logic [SAMPLE_W-1:0] rd_c, rd_r, rd_u, rd_d;

  logic                     s1_v_r;
  meta_t                    s1_meta_r;
  logic                     s2_v_r;
  meta_t                    s2_meta_r;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic [SAMPLE_W-1:0]      pc_r;
  logic                     out_v_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [IDX_W-1:0]         oidx_r;
  logic                     vend_r, rlast_r;
  logic signed [VALUE_W:0]  prod;

  assign n_eff = clamp_n(grid_r, MAXG);
  assign total = grid_total(n_eff, shape_r);
  assign scale = grid_scale(n_eff);

  assign nb0  = nb_info(cur_r, n_eff, shape_r);
  assign cur1 = cur_next(cur_r, n_eff, shape_r);
  assign nb1  = nb_info(cur1, n_eff, shape_r);

  assign elig0   = (cur_r.idx != total) && (fin_r || (nb0.ln < wr_cnt_r));
  assign elig1   = (cur1.idx != total) && (fin_r || (nb1.ln < wr_cnt_r));
  assign adv     = !out_v_r || out_stream.ready;
  assign issue   = elig0 && adv;
  assign end_vec = issue && (cur1.idx == total);

  assign in_stream.ready = !elig0 || (issue && !elig1);
  assign in_fire         = in_stream.valid && in_stream.ready;

  always_comb begin
    grid_nxt   = grid_r;
    shape_nxt  = shape_r;
    cur_nxt    = cur_r;
    fin_nxt    = fin_r;
    wr_base    = wr_cnt_r;
    if (end_vec) begin
      cur_nxt = '0;
      wr_base = '0;
      fin_nxt = 1'b0;
    end else if (issue) begin
      cur_nxt = cur1;
    end
    wr_cnt_nxt = wr_base;
    if (in_fire) begin
      wr_cnt_nxt = wr_base + IDX_W'(1);
      fin_nxt    = (wr_base + IDX_W'(1)) >= total;
    end
    if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIZE: begin
          grid_nxt   = cfg_data[GRID_W-1:0];
          cur_nxt    = '0;
          wr_cnt_nxt = '0;
          fin_nxt    = 1'b0;
        end
        CFG_DOMAIN_SHAPE: begin
          shape_nxt  = shape_t'(cfg_data[0]);
          cur_nxt    = '0;
          wr_cnt_nxt = '0;
          fin_nxt    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r   <= GRID_SIZE_RST;
      shape_r  <= SHAPE_SQUARE;
      cur_r    <= '0;
      wr_cnt_r <= '0;
      fin_r    <= 1'b0;
    end else begin
      grid_r   <= grid_nxt;
      shape_r  <= shape_nxt;
      cur_r    <= cur_nxt;
      wr_cnt_r <= wr_cnt_nxt;
      fin_r    <= fin_nxt;
    end
  end

  fpsa_window #(.WIN_AW(WIN_AW)) u_window (
    .clk     (clk),
    .we      (in_fire),
    .waddr   (wr_base[WIN_AW-1:0]),
    .wdata   (in_stream.sample),
    .re      (issue),
    .raddr_c (cur_r.idx[WIN_AW-1:0]),
    .raddr_r (cur1.idx[WIN_AW-1:0]),
    .raddr_u (nb0.up[WIN_AW-1:0]),
    .raddr_d (nb0.dn[WIN_AW-1:0]),
    .rdata_c (rd_c),
    .rdata_r (rd_r),
    .rdata_u (rd_u),
    .rdata_d (rd_d)
  );

  // left neighbour is the centre word of the previous result
  always_comb begin
    diff_nxt = {{(DIFF_W-SAMPLE_W){rd_c[SAMPLE_W-1]}}, rd_c} <<< 2;
    if (s1_meta_r.has_l)
      diff_nxt = diff_nxt - {{(DIFF_W-SAMPLE_W){pc_r[SAMPLE_W-1]}}, pc_r};
    if (s1_meta_r.has_r)
      diff_nxt = diff_nxt - {{(DIFF_W-SAMPLE_W){rd_r[SAMPLE_W-1]}}, rd_r};
    if (s1_meta_r.has_u)
      diff_nxt = diff_nxt - {{(DIFF_W-SAMPLE_W){rd_u[SAMPLE_W-1]}}, rd_u};
    if (s1_meta_r.has_d)
      diff_nxt = diff_nxt - {{(DIFF_W-SAMPLE_W){rd_d[SAMPLE_W-1]}}, rd_d};
  end

  assign prod = diff_r * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r <= '{has_l: nb0.has_l, has_r: nb0.has_r, has_u: nb0.has_u,
                     has_d: nb0.has_d, idx: cur_r.idx,
                     vend: (cur1.idx == total), rlast: !elig1};
      s2_meta_r <= s1_meta_r;
      diff_r    <= diff_nxt;
      if (s1_v_r) pc_r <= rd_c;
      val_r     <= prod[VALUE_W-1:0];
      oidx_r    <= s2_meta_r.idx;
      vend_r    <= s2_meta_r.vend;
      rlast_r   <= s2_meta_r.rlast;
    end
  end

  assign out_stream.valid        = out_v_r;
  assign out_stream.result_value = val_r;
  assign out_stream.result_index = oidx_r;
  assign out_stream.vector_end   = vend_r;
  assign out_stream.run_last     = rlast_r;

endmodule

// ----- hdl/fpsa_checker.sv -----
// Port-level checker for the stencil core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fpsa_checker
  import fpsa_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] result_value,
  input logic [IDX_W-1:0]          result_index,
  input logic                      vector_end,
  input logic                      run_last
);

  `FPSA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(result_index), "stalled result changed")
  `FPSA_ASSERT(a_end_is_last, clk, rst_n, out_valid && vector_end |-> run_last, "vector end without run_last")
  `FPSA_ASSERT(a_restart_zero, clk, rst_n, out_valid && out_ready && vector_end |=> !out_valid || result_index == '0, "vector did not restart at index zero")
  `FPSA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind five_point_stencil_apply_core fpsa_checker u_fpsa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_stream.valid),
  .out_ready    (out_stream.ready),
  .result_value (out_stream.result_value),
  .result_index (out_stream.result_index),
  .vector_end   (out_stream.vector_end),
  .run_last     (out_stream.run_last)
);
